>>> hw/rtl/map_reduce_task_dispatcher_unit_macros.svh
// assertion macros, compiled out for synthesis
`ifndef MAP_REDUCE_TASK_DISPATCHER_UNIT_MACROS_SVH
`define MAP_REDUCE_TASK_DISPATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MRTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mrtd check failed");
`define MRTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mrtd check failed");
`else
`define MRTD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MRTD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/mrtd_pkg.sv
package mrtd_pkg;

    localparam int CHUNK      = 16;
    localparam int CHUNK_W    = 4;
    localparam int IDX_W      = 7;
    localparam int CH_W       = 3;
    localparam int CNT_W      = 8;
    localparam int CFG_MAP_W  = 7;
    localparam int CFG_RED_W  = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_MAP_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_REDUCE_COUNT = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] TYPE_NONE   = 2'd0;
    localparam logic [1:0] TYPE_MAP    = 2'd1;
    localparam logic [1:0] TYPE_REDUCE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic             set_asg;
        logic             set_done;
        logic [IDX_W-1:0] idx;
    } tbl_cmd_t;

    typedef struct packed {
        logic                 all_done;
        logic                 success;
        logic [CFG_MAP_W-1:0] file_count;
        logic [5:0]           granted_index;
        logic [1:0]           granted_type;
        logic                 found;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

>>> hw/rtl/mrtd_ffs.sv
module mrtd_ffs (
    input  logic [mrtd_pkg::CHUNK-1:0]   free_bits,
    input  logic [mrtd_pkg::IDX_W-1:0]   base,
    input  logic [mrtd_pkg::IDX_W-1:0]   limit,
    output logic                         hit,
    output logic [mrtd_pkg::CHUNK_W-1:0] offset
);
    import mrtd_pkg::*;

    // lowest free lane whose entry lies below the limit
    always_comb begin
        hit    = 1'b0;
        offset = '0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            if (free_bits[i] &&
                (({1'b0, base} + (IDX_W + 1)'(i)) < {1'b0, limit})) begin
                hit    = 1'b1;
                offset = CHUNK_W'(i);
            end
        end
    end

endmodule

>>> hw/rtl/mrtd_table.sv
module mrtd_table #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mrtd_pkg::CH_W-1:0]  chunk_sel,
    input  mrtd_pkg::tbl_cmd_t         cmd,
    output logic [mrtd_pkg::CHUNK-1:0] free_chunk
);
    import mrtd_pkg::*;

    localparam int NCH   = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW    = (1 << CIW) * CHUNK;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] asg_reg, asg_next;
    logic [DEPTH-1:0] cmp_reg, cmp_next;
    logic [PW-1:0]    free_pad;

    always_comb begin
        asg_next = asg_reg;
        cmp_next = cmp_reg;
        if (cmd.set_asg) begin
            asg_next[cmd.idx[IW-1:0]] = 1'b1;
        end
        if (cmd.set_done) begin
            asg_next[cmd.idx[IW-1:0]] = 1'b0;
            cmp_next[cmd.idx[IW-1:0]] = 1'b1;
        end
    end

    always_comb begin
        free_pad              = '0;
        free_pad[DEPTH-1:0]   = ~asg_reg & ~cmp_reg;
    end

    assign free_chunk = free_pad[chunk_sel[CIW-1:0] * CHUNK +: CHUNK];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asg_reg <= '0;
            cmp_reg <= '0;
        end else begin
            asg_reg <= asg_next;
            cmp_reg <= cmp_next;
        end
    end

endmodule

>>> hw/rtl/map_reduce_task_dispatcher_unit.sv
// map/reduce task dispatcher
// s_ channel takes one item per handshake: s_tuser is the kind (request or
// completion report), s_tdata carries the reported task type and index.
// m_ channel returns exactly one result item per input item.
// cfg_we/cfg_addr/cfg_wdata write the map and reduce task counts; write only
// while no item is in flight.
// a report is applied at acceptance and its result is on m_ in the next cycle,
// so reports can stream at one item per cycle while m_tready is high.
// a request scans the flag table of its phase sixteen entries per cycle through
// one shared find-first unit, stopping at the first free task; the result is
// registered when the scan ends, and s_tready is low while scanning.
// the single output register holds a result until m_tready; while it is full
// and not taken no new item is accepted.
// reset clears all task flags, completion counters and the finished flag,
// sets the map count to 0 and the reduce count to 4.
`include "map_reduce_task_dispatcher_unit_macros.svh"
module map_reduce_task_dispatcher_unit #(
    parameter int MAX_MAP_TASKS    = 64,
    parameter int MAX_REDUCE_TASKS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mrtd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mrtd_pkg::CFG_MAP_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // task_type, task_index
    input  logic [mrtd_pkg::S_DATA_W-1:0]    s_tdata,
    // kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // found, granted_type, granted_index, file_count, success, all_done
    output logic [mrtd_pkg::M_DATA_W-1:0]    m_tdata
);
    import mrtd_pkg::*;

    localparam int MAP_D = (MAX_MAP_TASKS > 127) ? 127 : MAX_MAP_TASKS;
    localparam int RED_D = (MAX_REDUCE_TASKS > 31) ? 31 : MAX_REDUCE_TASKS;
    localparam logic [CFG_MAP_W-1:0] MAP_CAP = CFG_MAP_W'(MAP_D);
    localparam logic [CFG_RED_W-1:0] RED_CAP = CFG_RED_W'(RED_D);

    state_t               state_reg, state_next;
    logic [CH_W-1:0]      chunk_reg, chunk_next;
    logic                 phase_map_reg, phase_map_next;
    logic [CFG_MAP_W-1:0] map_cfg_reg, map_cfg_next;
    logic [CFG_RED_W-1:0] red_cfg_reg, red_cfg_next;
    logic [CNT_W-1:0]     map_cnt_reg, map_cnt_next;
    logic [CNT_W-1:0]     red_cnt_reg, red_cnt_next;
    logic                 finished_reg, finished_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic [CFG_MAP_W-1:0] map_eff;
    logic [CFG_RED_W-1:0] red_eff;
    logic                 s_acc;
    logic [1:0]           in_type;
    logic [5:0]           in_index;
    logic                 rep_map, rep_red;
    logic [CNT_W-1:0]     map_cnt_upd, red_cnt_upd;
    logic                 fin_upd;
    logic [IDX_W-1:0]     base, limit, grant_idx;
    logic [CHUNK-1:0]     map_free, red_free, free_sel;
    logic                 hit, last, scan_done;
    logic [CHUNK_W-1:0]   offset;
    tbl_cmd_t             map_cmd, red_cmd;

    assign map_eff  = (map_cfg_reg > MAP_CAP) ? MAP_CAP : map_cfg_reg;
    assign red_eff  = (red_cfg_reg > RED_CAP) ? RED_CAP : red_cfg_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign in_type  = s_tdata[1:0];
    assign in_index = s_tdata[7:2];

    // report handling
    assign rep_map = (s_tuser == KIND_REPORT) && (in_type == TYPE_MAP) &&
                     ({1'b0, in_index} < map_eff);
    assign rep_red = (s_tuser == KIND_REPORT) && (in_type == TYPE_REDUCE) &&
                     ({1'b0, in_index} < {2'b0, red_eff});
    assign map_cnt_upd = rep_map ? sat_inc(map_cnt_reg) : map_cnt_reg;
    assign red_cnt_upd = rep_red ? sat_inc(red_cnt_reg) : red_cnt_reg;
    assign fin_upd     = finished_reg ||
                         ((map_cnt_upd >= {1'b0, map_eff}) &&
                          (red_cnt_upd >= {3'b0, red_eff}));

    // scan datapath
    assign base      = {chunk_reg, {CHUNK_W{1'b0}}};
    assign limit     = phase_map_reg ? map_eff : {2'b0, red_eff};
    assign free_sel  = phase_map_reg ? map_free : red_free;
    assign grant_idx = base + {{(IDX_W - CHUNK_W){1'b0}}, offset};
    assign last      = ({1'b0, base} + (IDX_W + 1)'(CHUNK)) >= {1'b0, limit};
    assign scan_done = (state_reg == ST_SCAN) && (hit || last);

    mrtd_ffs u_ffs (
        .free_bits (free_sel),
        .base      (base),
        .limit     (limit),
        .hit       (hit),
        .offset    (offset)
    );

    always_comb begin
        map_cmd.set_asg  = (state_reg == ST_SCAN) && phase_map_reg && hit;
        map_cmd.set_done = s_acc && rep_map;
        map_cmd.idx      = (state_reg == ST_SCAN) ? grant_idx : {1'b0, in_index};
        red_cmd.set_asg  = (state_reg == ST_SCAN) && !phase_map_reg && hit;
        red_cmd.set_done = s_acc && rep_red;
        red_cmd.idx      = (state_reg == ST_SCAN) ? grant_idx : {1'b0, in_index};
    end

    mrtd_table #(.DEPTH(MAP_D)) u_map_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .chunk_sel  (chunk_reg),
        .cmd        (map_cmd),
        .free_chunk (map_free)
    );

    mrtd_table #(.DEPTH(RED_D)) u_red_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .chunk_sel  (chunk_reg),
        .cmd        (red_cmd),
        .free_chunk (red_free)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == KIND_REQUEST)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = !out_valid_reg || m_tready;
            ST_SCAN: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // datapath registers
    always_comb begin
        chunk_next     = chunk_reg;
        phase_map_next = phase_map_reg;
        map_cnt_next   = map_cnt_reg;
        red_cnt_next   = red_cnt_reg;
        finished_next  = finished_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        map_cfg_next   = map_cfg_reg;
        red_cfg_next   = red_cfg_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_COUNT:    map_cfg_next = cfg_wdata;
                REG_REDUCE_COUNT: red_cfg_next = cfg_wdata[CFG_RED_W-1:0];
                default:          map_cfg_next = map_cfg_reg;
            endcase
        end

        if (s_acc) begin
            if (s_tuser == KIND_REQUEST) begin
                chunk_next     = '0;
                phase_map_next = map_cnt_reg < {1'b0, map_eff};
            end else begin
                map_cnt_next                = map_cnt_upd;
                red_cnt_next                = red_cnt_upd;
                finished_next               = fin_upd;
                out_valid_next              = 1'b1;
                out_data_next.found         = 1'b0;
                out_data_next.granted_type  = TYPE_NONE;
                out_data_next.granted_index = '0;
                out_data_next.file_count    = '0;
                out_data_next.success       = 1'b1;
                out_data_next.all_done      = fin_upd;
            end
        end

        if (state_reg == ST_SCAN) begin
            chunk_next = chunk_reg + 1'b1;
            if (scan_done) begin
                out_valid_next              = 1'b1;
                out_data_next.found         = hit;
                out_data_next.granted_type  = !hit ? TYPE_NONE :
                                              (phase_map_reg ? TYPE_MAP : TYPE_REDUCE);
                out_data_next.granted_index = hit ? grant_idx[5:0] : 6'd0;
                out_data_next.file_count    = hit ? map_eff : '0;
                out_data_next.success       = 1'b0;
                out_data_next.all_done      = finished_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            phase_map_reg <= 1'b0;
            map_cfg_reg   <= '0;
            red_cfg_reg   <= CFG_RED_W'(4);
            map_cnt_reg   <= '0;
            red_cnt_reg   <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            phase_map_reg <= phase_map_next;
            map_cfg_reg   <= map_cfg_next;
            red_cfg_reg   <= red_cfg_next;
            map_cnt_reg   <= map_cnt_next;
            red_cnt_reg   <= red_cnt_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    `MRTD_ASSERT_NXT(a_report_acked, aclk, aresetn, s_acc && (s_tuser == KIND_REPORT), out_valid_reg && out_data_reg.success)
    `MRTD_ASSERT_NXT(a_finished_sticky, aclk, aresetn, finished_reg, finished_reg)
    `MRTD_ASSERT_IMP(a_grant_in_range, aclk, aresetn, (state_reg == ST_SCAN) && hit, grant_idx < limit)
    `MRTD_ASSERT_IMP(a_out_free_at_scan_end, aclk, aresetn, scan_done, !out_valid_reg)

endmodule
